// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent-assertion shorthands for the decoder checker.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, masked while reset is high.
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, masked while reset is high.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/tepd_pkg.sv =====
// ----------------------------------------------------------------------------
// tepd_pkg
// Widths, result kinds, status codes and the run record for the decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tepd_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 5;
   localparam int VALUE_W     = 62;
   localparam int INDEX_W     = 16;
   localparam int STATUS_W    = 2;
   localparam int RUN_W       = 3;
   localparam int RSP_DATA_W  = VALUE_W + 2 * INDEX_W + STATUS_W;
   localparam int QUEUE_DEPTH = 4;

   localparam logic [KIND_W-1:0] KIND_EVENT_ID   = 5'd0;
   localparam logic [KIND_W-1:0] KIND_LENGTH     = 5'd1;
   localparam logic [KIND_W-1:0] KIND_RECT_LEFT  = 5'd11;
   localparam logic [KIND_W-1:0] KIND_ORIENT     = 5'd15;
   localparam logic [KIND_W-1:0] KIND_PRESSURE   = 5'd16;
   localparam logic [KIND_W-1:0] KIND_END        = 5'd17;

   localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_DONE  = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TRUNC = 2'd2;

   // Everything one byte yields: an optional decoded field, a run of
   // zero-valued absent fields with consecutive kinds, an optional end beat.
   typedef struct packed {
      logic                has_field;
      logic [KIND_W-1:0]   kind;
      logic [VALUE_W-1:0]  value;
      logic [INDEX_W-1:0]  frame;
      logic [INDEX_W-1:0]  contact;
      logic [KIND_W-1:0]   zero_kind;
      logic [RUN_W-1:0]    zero_count;
      logic                has_end;
      logic [STATUS_W-1:0] end_status;
   } run_rec_type;

endpackage

`default_nettype wire

// ===== rtl/tepd_front.sv =====
// ----------------------------------------------------------------------------
// tepd_front
// Byte parser: header pass-through, variable-length integer decode, frame and
// contact bookkeeping. Emits one run record per byte that yields results.
// ----------------------------------------------------------------------------
`default_nettype none

module tepd_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            in_valid,
   output logic                            in_ready,
   input  logic [tepd_pkg::BYTE_W-1:0]     in_byte,
   input  logic                            in_last,
   input  logic                            q_space,
   output logic                            rec_push,
   output tepd_pkg::run_rec_type           rec
);

   localparam int PHASE_W = 5;
   localparam int ACC_W   = 61;
   localparam int LEN_W   = 32;
   localparam int HDR_W   = 3;
   localparam int REM_W   = 3;
   localparam int MASK_W  = 3;
   localparam int MAG_W   = 30;
   localparam int ENC_W   = 3;

   localparam logic [PHASE_W-1:0] PH_HDR      = 5'd0;
   localparam logic [PHASE_W-1:0] PH_TIME     = 5'd1;
   localparam logic [PHASE_W-1:0] PH_FRAMES   = 5'd2;
   localparam logic [PHASE_W-1:0] PH_CONTACTS = 5'd3;
   localparam logic [PHASE_W-1:0] PH_OFFSET   = 5'd4;
   localparam logic [PHASE_W-1:0] PH_CID      = 5'd5;
   localparam logic [PHASE_W-1:0] PH_MASK     = 5'd6;
   localparam logic [PHASE_W-1:0] PH_X        = 5'd7;
   localparam logic [PHASE_W-1:0] PH_Y        = 5'd8;
   localparam logic [PHASE_W-1:0] PH_FLAGS    = 5'd9;
   localparam logic [PHASE_W-1:0] PH_RL       = 5'd10;
   localparam logic [PHASE_W-1:0] PH_RT       = 5'd11;
   localparam logic [PHASE_W-1:0] PH_RR       = 5'd12;
   localparam logic [PHASE_W-1:0] PH_RB       = 5'd13;
   localparam logic [PHASE_W-1:0] PH_ORIENT   = 5'd14;
   localparam logic [PHASE_W-1:0] PH_PRES     = 5'd15;
   localparam logic [PHASE_W-1:0] PH_DONE     = 5'd16;

   localparam logic [ENC_W-1:0] ENC_RAW = 3'd0;
   localparam logic [ENC_W-1:0] ENC_U2  = 3'd1;
   localparam logic [ENC_W-1:0] ENC_S2  = 3'd2;
   localparam logic [ENC_W-1:0] ENC_U4  = 3'd3;
   localparam logic [ENC_W-1:0] ENC_S4  = 3'd4;
   localparam logic [ENC_W-1:0] ENC_U8  = 3'd5;

   localparam logic [HDR_W-1:0] HDR_ID_LO = 3'd0;
   localparam logic [HDR_W-1:0] HDR_ID_HI = 3'd1;
   localparam logic [HDR_W-1:0] HDR_LEN_0 = 3'd2;
   localparam logic [HDR_W-1:0] HDR_LEN_1 = 3'd3;
   localparam logic [HDR_W-1:0] HDR_LEN_2 = 3'd4;
   localparam logic [HDR_W-1:0] HDR_LEN_3 = 3'd5;

   logic [PHASE_W-1:0]           phase_ff, phase_in;
   logic [HDR_W-1:0]             hdr_count_ff, hdr_count_in;
   logic [LEN_W-1:0]             length_ff, length_in;
   logic [LEN_W-1:0]             seen_ff, seen_in;
   logic [ACC_W-1:0]             acc_ff, acc_in;
   logic [REM_W-1:0]             remain_ff, remain_in;
   logic                         neg_ff, neg_in;
   logic [tepd_pkg::INDEX_W-1:0] frames_left_ff, frames_left_in;
   logic [tepd_pkg::INDEX_W-1:0] frame_idx_ff, frame_idx_in;
   logic [tepd_pkg::INDEX_W-1:0] contacts_left_ff, contacts_left_in;
   logic [tepd_pkg::INDEX_W-1:0] contact_idx_ff, contact_idx_in;
   logic [MASK_W-1:0]            mask_ff, mask_in;

   logic                         accept;
   logic [ENC_W-1:0]             enc;
   logic [REM_W-1:0]             first_cnt;
   logic [tepd_pkg::BYTE_W-1:0]  first_val;
   logic                         first_neg;
   logic [ACC_W-1:0]             raw_next;
   logic [REM_W-1:0]             rem_next;
   logic                         neg_use;
   logic                         val_done;
   logic [MAG_W-1:0]             neg_mag;
   logic [tepd_pkg::VALUE_W-1:0] field_val;
   logic                         rect_done, orient_done, cdone, nframe, fin_ok;

   assign in_ready = q_space;
   assign accept   = in_valid & q_space;
   assign rec_push = accept & (rec.has_field | rec.has_end);

   // Encoding of the field expected in each body phase.
   always_comb begin
      case (phase_ff)
         PH_TIME, PH_FLAGS, PH_ORIENT, PH_PRES: enc = ENC_U4;
         PH_FRAMES, PH_CONTACTS, PH_MASK:       enc = ENC_U2;
         PH_OFFSET:                             enc = ENC_U8;
         PH_X, PH_Y:                            enc = ENC_S4;
         PH_RL, PH_RT, PH_RR, PH_RB:            enc = ENC_S2;
         default:                               enc = ENC_RAW;
      endcase
   end

   // Split a first byte into follow-on count, value bits and sign.
   always_comb begin
      first_cnt = '0;
      first_val = in_byte;
      first_neg = 1'b0;
      case (enc)
         ENC_U2: begin
            first_cnt = REM_W'(in_byte[7]);
            first_val = {1'b0, in_byte[6:0]};
         end
         ENC_S2: begin
            first_cnt = REM_W'(in_byte[7]);
            first_val = {2'b0, in_byte[5:0]};
            first_neg = in_byte[6];
         end
         ENC_U4: begin
            first_cnt = REM_W'(in_byte[7:6]);
            first_val = {2'b0, in_byte[5:0]};
         end
         ENC_S4: begin
            first_cnt = REM_W'(in_byte[7:6]);
            first_val = {3'b0, in_byte[4:0]};
            first_neg = in_byte[5];
         end
         ENC_U8: begin
            first_cnt = in_byte[7:5];
            first_val = {3'b0, in_byte[4:0]};
         end
         default: begin
            first_cnt = '0;
            first_val = in_byte;
         end
      endcase
   end

   always_comb begin
      if (remain_ff != '0) begin
         raw_next = {acc_ff[ACC_W-tepd_pkg::BYTE_W-1:0], in_byte};
         rem_next = remain_ff - REM_W'(1);
         neg_use  = neg_ff;
         val_done = (remain_ff == REM_W'(1));
      end else begin
         raw_next = ACC_W'(first_val);
         rem_next = first_cnt;
         neg_use  = first_neg;
         val_done = (first_cnt == '0);
      end
   end

   // Signed magnitudes stay within 29 bits; negate narrow, then sign-extend.
   assign neg_mag   = MAG_W'(0) - raw_next[MAG_W-1:0];
   assign field_val = neg_use ?
                      {{(tepd_pkg::VALUE_W-MAG_W){neg_mag[MAG_W-1]}}, neg_mag} :
                      tepd_pkg::VALUE_W'(raw_next);

   always_comb begin
      phase_in         = phase_ff;
      hdr_count_in     = hdr_count_ff;
      length_in        = length_ff;
      seen_in          = seen_ff;
      acc_in           = acc_ff;
      remain_in        = remain_ff;
      neg_in           = neg_ff;
      frames_left_in   = frames_left_ff;
      frame_idx_in     = frame_idx_ff;
      contacts_left_in = contacts_left_ff;
      contact_idx_in   = contact_idx_ff;
      mask_in          = mask_ff;
      rect_done        = 1'b0;
      orient_done      = 1'b0;
      cdone            = 1'b0;
      nframe           = 1'b0;
      fin_ok           = 1'b0;
      rec              = '0;
      rec.frame        = frame_idx_ff;
      rec.contact      = contact_idx_ff;

      if (accept && phase_ff != PH_DONE) begin
         seen_in = (seen_ff == '1) ? seen_ff : seen_ff + LEN_W'(1);
         if (phase_ff == PH_HDR) begin
            hdr_count_in = hdr_count_ff + HDR_W'(1);
            rec.frame    = '0;
            rec.contact  = '0;
            case (hdr_count_ff)
               HDR_ID_LO: begin
                  acc_in = ACC_W'(in_byte);
               end
               HDR_ID_HI: begin
                  rec.has_field = 1'b1;
                  rec.kind      = tepd_pkg::KIND_EVENT_ID;
                  rec.value     = tepd_pkg::VALUE_W'({in_byte, acc_ff[7:0]});
                  acc_in        = '0;
               end
               HDR_LEN_0: length_in[7:0]   = in_byte;
               HDR_LEN_1: length_in[15:8]  = in_byte;
               HDR_LEN_2: length_in[23:16] = in_byte;
               HDR_LEN_3: begin
                  length_in[31:24] = in_byte;
                  rec.has_field    = 1'b1;
                  rec.kind         = tepd_pkg::KIND_LENGTH;
                  rec.value        = tepd_pkg::VALUE_W'({in_byte, length_ff[23:0]});
                  phase_in         = PH_TIME;
               end
               default: ;
            endcase
         end else if (!val_done) begin
            acc_in    = raw_next;
            remain_in = rem_next;
            neg_in    = neg_use;
         end else begin
            acc_in        = '0;
            remain_in     = '0;
            neg_in        = 1'b0;
            rec.has_field = 1'b1;
            rec.kind      = tepd_pkg::KIND_W'(phase_ff + PHASE_W'(1));
            rec.value     = field_val;
            case (phase_ff)
               PH_TIME: phase_in = PH_FRAMES;
               PH_FRAMES: begin
                  frames_left_in = field_val[tepd_pkg::INDEX_W-1:0];
                  frame_idx_in   = '0;
                  contact_idx_in = '0;
                  if (field_val[tepd_pkg::INDEX_W-1:0] == '0) begin
                     fin_ok = 1'b1;
                  end else begin
                     phase_in = PH_CONTACTS;
                  end
               end
               PH_CONTACTS: begin
                  contacts_left_in = field_val[tepd_pkg::INDEX_W-1:0];
                  contact_idx_in   = '0;
                  phase_in         = PH_OFFSET;
               end
               PH_OFFSET: begin
                  if (contacts_left_ff == '0) begin
                     nframe = 1'b1;
                  end else begin
                     phase_in = PH_CID;
                  end
               end
               PH_CID: phase_in = PH_MASK;
               PH_MASK: begin
                  mask_in  = field_val[MASK_W-1:0];
                  phase_in = PH_X;
               end
               PH_X: phase_in = PH_Y;
               PH_Y: phase_in = PH_FLAGS;
               PH_FLAGS: begin
                  if (mask_ff[0]) begin
                     phase_in = PH_RL;
                  end else begin
                     rec.zero_kind  = tepd_pkg::KIND_RECT_LEFT;
                     rec.zero_count = tepd_pkg::RUN_W'(4);
                     rect_done      = 1'b1;
                  end
               end
               PH_RL, PH_RT, PH_RR: phase_in = phase_ff + PHASE_W'(1);
               PH_RB: rect_done = 1'b1;
               PH_ORIENT: orient_done = 1'b1;
               PH_PRES: cdone = 1'b1;
               default: ;
            endcase

            // Fill absent optional fields with zero, then close the contact.
            if (rect_done) begin
               if (mask_ff[1]) begin
                  phase_in = PH_ORIENT;
               end else begin
                  if (rec.zero_count == '0) rec.zero_kind = tepd_pkg::KIND_ORIENT;
                  rec.zero_count = rec.zero_count + tepd_pkg::RUN_W'(1);
                  orient_done    = 1'b1;
               end
            end
            if (orient_done) begin
               if (mask_ff[2]) begin
                  phase_in = PH_PRES;
               end else begin
                  if (rec.zero_count == '0) rec.zero_kind = tepd_pkg::KIND_PRESSURE;
                  rec.zero_count = rec.zero_count + tepd_pkg::RUN_W'(1);
                  cdone          = 1'b1;
               end
            end
            if (cdone) begin
               contacts_left_in = contacts_left_ff - tepd_pkg::INDEX_W'(1);
               contact_idx_in   = contact_idx_ff + tepd_pkg::INDEX_W'(1);
               if (contacts_left_in == '0) begin
                  nframe = 1'b1;
               end else begin
                  phase_in = PH_CID;
               end
            end
            if (nframe) begin
               frames_left_in = frames_left_ff - tepd_pkg::INDEX_W'(1);
               frame_idx_in   = frame_idx_ff + tepd_pkg::INDEX_W'(1);
               contact_idx_in = '0;
               if (frames_left_in == '0) begin
                  fin_ok = 1'b1;
               end else begin
                  phase_in = PH_CONTACTS;
               end
            end
         end

         if (fin_ok) begin
            rec.has_end    = 1'b1;
            rec.end_status = tepd_pkg::STATUS_DONE;
            phase_in       = PH_DONE;
         end
         if (phase_in != PH_DONE && phase_in != PH_HDR &&
             (seen_in >= length_in || in_last)) begin
            rec.has_end    = 1'b1;
            rec.end_status = tepd_pkg::STATUS_TRUNC;
            phase_in       = PH_DONE;
         end
         if (phase_in != PH_DONE && in_last) begin
            rec.has_end    = 1'b1;
            rec.end_status = tepd_pkg::STATUS_TRUNC;
            phase_in       = PH_DONE;
         end
      end

      // The transport's last byte starts a fresh message.
      if (accept && in_last) begin
         phase_in         = PH_HDR;
         hdr_count_in     = '0;
         length_in        = '0;
         seen_in          = '0;
         acc_in           = '0;
         remain_in        = '0;
         neg_in           = 1'b0;
         frames_left_in   = '0;
         frame_idx_in     = '0;
         contacts_left_in = '0;
         contact_idx_in   = '0;
         mask_in          = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff         <= PH_HDR;
         hdr_count_ff     <= '0;
         length_ff        <= '0;
         seen_ff          <= '0;
         acc_ff           <= '0;
         remain_ff        <= '0;
         neg_ff           <= 1'b0;
         frames_left_ff   <= '0;
         frame_idx_ff     <= '0;
         contacts_left_ff <= '0;
         contact_idx_ff   <= '0;
         mask_ff          <= '0;
      end else begin
         phase_ff         <= phase_in;
         hdr_count_ff     <= hdr_count_in;
         length_ff        <= length_in;
         seen_ff          <= seen_in;
         acc_ff           <= acc_in;
         remain_ff        <= remain_in;
         neg_ff           <= neg_in;
         frames_left_ff   <= frames_left_in;
         frame_idx_ff     <= frame_idx_in;
         contacts_left_ff <= contacts_left_in;
         contact_idx_ff   <= contact_idx_in;
         mask_ff          <= mask_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tepd_queue.sv =====
// ----------------------------------------------------------------------------
// tepd_queue
// Short FIFO of run records between the parser and the beat expander.
// ----------------------------------------------------------------------------
`default_nettype none

module tepd_queue #(
   parameter int DEPTH = tepd_pkg::QUEUE_DEPTH
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  tepd_pkg::run_rec_type push_data,
   output logic                  space,
   input  logic                  pop,
   output tepd_pkg::run_rec_type pop_data,
   output logic                  avail
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);

   tepd_pkg::run_rec_type slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign space    = (count_ff != FULL_CNT);
   assign avail    = (count_ff != '0);
   assign pop_data = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push) wr_ptr_in = (wr_ptr_ff == LAST_SLOT) ? '0 : wr_ptr_ff + PTR_W'(1);
      if (pop)  rd_ptr_in = (rd_ptr_ff == LAST_SLOT) ? '0 : rd_ptr_ff + PTR_W'(1);
      count_in = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/tepd_back.sv =====
// ----------------------------------------------------------------------------
// tepd_back
// Beat expander: walks one run record and presents its results one beat each.
// ----------------------------------------------------------------------------
`default_nettype none

module tepd_back (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              head_avail,
   input  tepd_pkg::run_rec_type             head,
   output logic                              head_pop,
   output logic                              out_valid,
   input  logic                              out_ready,
   output logic [tepd_pkg::KIND_W-1:0]       out_kind,
   output logic [tepd_pkg::VALUE_W-1:0]      out_value,
   output logic [tepd_pkg::INDEX_W-1:0]      out_frame,
   output logic [tepd_pkg::INDEX_W-1:0]      out_contact,
   output logic [tepd_pkg::STATUS_W-1:0]     out_status,
   output logic                              out_last
);

   localparam int STEP_W  = tepd_pkg::RUN_W;
   localparam int TOTAL_W = STEP_W + 1;

   tepd_pkg::run_rec_type cur_ff, cur_in;
   logic                  cur_valid_ff, cur_valid_in;
   logic [STEP_W-1:0]     step_ff, step_in;
   logic [TOTAL_W-1:0]    total;
   logic [TOTAL_W-1:0]    zidx;
   logic                  fire, load;

   assign total = TOTAL_W'(cur_ff.has_field) + TOTAL_W'(cur_ff.zero_count) +
                  TOTAL_W'(cur_ff.has_end);
   assign zidx  = TOTAL_W'(step_ff) - TOTAL_W'(cur_ff.has_field);

   assign out_valid = cur_valid_ff;
   assign out_last  = (TOTAL_W'(step_ff) + TOTAL_W'(1) == total);
   assign fire      = cur_valid_ff & out_ready;
   assign load      = !cur_valid_ff | (fire & out_last);
   assign head_pop  = load & head_avail;

   always_comb begin
      out_kind    = tepd_pkg::KIND_END;
      out_value   = '0;
      out_frame   = '0;
      out_contact = '0;
      out_status  = cur_ff.end_status;
      if (cur_ff.has_field && step_ff == '0) begin
         out_kind    = cur_ff.kind;
         out_value   = cur_ff.value;
         out_frame   = cur_ff.frame;
         out_contact = cur_ff.contact;
         out_status  = tepd_pkg::STATUS_OK;
      end else if (zidx < TOTAL_W'(cur_ff.zero_count)) begin
         out_kind    = cur_ff.zero_kind + tepd_pkg::KIND_W'(zidx[STEP_W-1:0]);
         out_frame   = cur_ff.frame;
         out_contact = cur_ff.contact;
         out_status  = tepd_pkg::STATUS_OK;
      end
   end

   always_comb begin
      cur_in       = cur_ff;
      cur_valid_in = cur_valid_ff;
      step_in      = step_ff;
      if (load) begin
         cur_in       = head;
         cur_valid_in = head_avail;
         step_in      = '0;
      end else if (fire) begin
         step_in = step_ff + STEP_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
         step_ff      <= '0;
      end else begin
         cur_valid_ff <= cur_valid_in;
         step_ff      <= step_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/touch_event_pdu_decoder.sv =====
// Path: a byte's results reach rsp through the record queue and the expander's registered record.
// Throughput: one req beat per cycle while the queue has room, and one rsp beat per cycle
//   while rsp_tready is high; a byte that yields several results holds the rsp side for a beat
//   each, and the record queue (QUEUE_DEPTH runs) lets req keep flowing meanwhile.
// Reset: synchronous; the parser expects a header, the queue and rsp stage empty.
// ----------------------------------------------------------------------------
// touch_event_pdu_decoder
// Byte-serial decoder for touch-event messages: header pass-through,
// variable-length field decode, absent-field fill and end/truncation report.
// ----------------------------------------------------------------------------
`default_nettype none

module touch_event_pdu_decoder #(
   parameter int QUEUE_DEPTH = tepd_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   // request side: message bytes
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tepd_pkg::BYTE_W-1:0]        req_tdata,   // [7:0] byte_value
   input  logic                               req_tlast,   // end_of_message
   // response side: decoded fields
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // [61:0] field_value, [77:62] frame_number, [93:78] contact_number, [95:94] status
   output logic [tepd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   output logic [tepd_pkg::KIND_W-1:0]        rsp_tuser,   // [4:0] field_kind
   output logic                               rsp_tlast    // last_of_run
);

   // Front: parse bytes into run records.
   tepd_pkg::run_rec_type          rec;
   logic                           rec_push;
   logic                           q_space;

   // Back: queue head feeding the beat expander.
   tepd_pkg::run_rec_type          head;
   logic                           head_avail;
   logic                           head_pop;

   logic [tepd_pkg::VALUE_W-1:0]   out_value;
   logic [tepd_pkg::INDEX_W-1:0]   out_frame;
   logic [tepd_pkg::INDEX_W-1:0]   out_contact;
   logic [tepd_pkg::STATUS_W-1:0]  out_status;

   // Accept a byte whenever the queue has room; the parser state advances
   // in the same cycle and its results drop into the queue as one record.
   tepd_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_byte  (req_tdata),
      .in_last  (req_tlast),
      .q_space  (q_space),
      .rec_push (rec_push),
      .rec      (rec)
   );

   // Hold records while the response side stalls.
   tepd_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (rec_push),
      .push_data (rec),
      .space     (q_space),
      .pop       (head_pop),
      .pop_data  (head),
      .avail     (head_avail)
   );

   // Expand each record into beats: decoded field, zero fills, end beat.
   tepd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .head_avail  (head_avail),
      .head        (head),
      .head_pop    (head_pop),
      .out_valid   (rsp_tvalid),
      .out_ready   (rsp_tready),
      .out_kind    (rsp_tuser),
      .out_value   (out_value),
      .out_frame   (out_frame),
      .out_contact (out_contact),
      .out_status  (out_status),
      .out_last    (rsp_tlast)
   );

   // Pack the response beat, first field in the lowest bits.
   assign rsp_tdata = {out_status, out_contact, out_frame, out_value};

endmodule

`default_nettype wire

// ===== rtl/tepd_checker.sv =====
// ----------------------------------------------------------------------------
// tepd_checker
// Port-level checks on the decoder's response beats, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module tepd_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_tvalid,
   input logic                             rsp_tready,
   input logic [tepd_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   input logic [tepd_pkg::KIND_W-1:0]      rsp_tuser,
   input logic                             rsp_tlast
);

   localparam int STATUS_LSB  = tepd_pkg::RSP_DATA_W - tepd_pkg::STATUS_W;

   logic [tepd_pkg::STATUS_W-1:0] beat_status;
   logic [tepd_pkg::VALUE_W-1:0]  beat_value;

   assign beat_status = rsp_tdata[STATUS_LSB +: tepd_pkg::STATUS_W];
   assign beat_value  = rsp_tdata[tepd_pkg::VALUE_W-1:0];

   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser) && $stable(rsp_tlast), "stalled rsp beat changed")

   `ASSERT_IMPLIES(a_kind_range, clock, reset, rsp_tvalid, rsp_tuser <= tepd_pkg::KIND_END, "rsp kind out of range")

   `ASSERT_IMPLIES(a_end_beat, clock, reset, rsp_tvalid && rsp_tuser == tepd_pkg::KIND_END, rsp_tlast && beat_status != tepd_pkg::STATUS_OK && beat_value == '0, "bad end beat")

   `ASSERT_IMPLIES(a_field_status, clock, reset, rsp_tvalid && rsp_tuser != tepd_pkg::KIND_END, beat_status == tepd_pkg::STATUS_OK, "field beat with end status")

endmodule

bind touch_event_pdu_decoder tepd_checker u_checker (.*);

`default_nettype wire
